@@ rtl/keypad_code_lock_lockout_assert.svh @@
// Assertion macros for the checker file of the code lock.
`ifndef KEYPAD_CODE_LOCK_LOCKOUT_ASSERT_SVH
`define KEYPAD_CODE_LOCK_LOCKOUT_ASSERT_SVH

// Clocked check, disabled while the given reset is high.
`define KCL_ASSERT(label, rst, prop, msg) \
   label: assert property (@(posedge clock) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define KCL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/kcl_pkg.sv @@
package kcl_pkg;

   localparam int NumLockRegs = 6;
   localparam logic [5:0] FirstLockSeconds = 6'd29;
   localparam logic [5:0] LastSecond = 6'd59;

   typedef enum logic [1:0] {
      CMD_KEY     = 2'd0,
      CMD_TIMEOUT = 2'd1,
      CMD_TICK    = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      STATUS_IDLE     = 3'd0,
      STATUS_DIGIT    = 3'd1,
      STATUS_MATCH    = 3'd2,
      STATUS_MISMATCH = 3'd3,
      STATUS_REJECT   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CSR_STORED_CODE = 3'd0,
      CSR_EMPTY_KEY   = 3'd1,
      CSR_LOCK_FIRST  = 3'd2,
      CSR_LOCK_SECOND = 3'd3,
      CSR_LOCK_THIRD  = 3'd4,
      CSR_LOCK_FOURTH = 3'd5,
      CSR_LOCK_FIFTH  = 3'd6,
      CSR_LOCK_LAST   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [63:0]                  stored_code;
      logic [7:0]                   empty_key;
      logic [NumLockRegs-1:0][7:0]  lock_minutes;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic        locked;
      logic [7:0]  minutes_left;
      logic [5:0]  seconds_left;
      logic [7:0]  wrong_attempts;
      logic [3:0]  digits_entered;
      logic        code_present;
   } rsp_type;

endpackage

@@ rtl/keypad_code_lock_lockout.sv @@
// Keypad code lock with wrong-attempt lockout. Every request beat (a key digit,
// an entry timeout or a one-second tick) yields exactly one response beat that
// reports the status of that event and the lock state after it. A beat passes
// an input register, one pass of update logic and a response register, and a
// new request is taken in every cycle while the response side keeps up. The
// response register lets a request enter while an earlier response still waits;
// the request side stalls only when both stages are full. Configuration is
// written through the csr_ port while no beat is in flight, a rule for the user
// that the block does not enforce; there is no clearing pass after reset.
module keypad_code_lock_lockout #(
   parameter int CODE_LENGTH = 8,
   parameter int LOCK_STEPS  = 6,
   parameter int FREE_TRIES  = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_key_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_locked,
   output logic [7:0]  rsp_minutes_left,
   output logic [5:0]  rsp_seconds_left,
   output logic [7:0]  rsp_wrong_attempts,
   output logic [3:0]  rsp_digits_entered,
   output logic        rsp_code_present,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   kcl_pkg::cfg_type cfg;
   kcl_pkg::rsp_type result;
   kcl_pkg::rsp_type rsp_ff;
   logic code_present;

   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_cmd_ff;
   logic [7:0] in_key_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       advance;
   logic       req_accept;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cmd_ff <= req_cmd;
         in_key_ff <= req_key_code;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   kcl_csr #(
      .CODE_LENGTH (CODE_LENGTH)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg),
      .code_present (code_present)
   );

   kcl_core #(
      .CODE_LENGTH (CODE_LENGTH),
      .LOCK_STEPS  (LOCK_STEPS),
      .FREE_TRIES  (FREE_TRIES)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .cmd          (in_cmd_ff),
      .key_code     (in_key_ff),
      .cfg          (cfg),
      .code_present (code_present),
      .result       (result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_locked         = rsp_ff.locked;
   assign rsp_minutes_left   = rsp_ff.minutes_left;
   assign rsp_seconds_left   = rsp_ff.seconds_left;
   assign rsp_wrong_attempts = rsp_ff.wrong_attempts;
   assign rsp_digits_entered = rsp_ff.digits_entered;
   assign rsp_code_present   = rsp_ff.code_present;

endmodule

@@ rtl/kcl_csr.sv @@
module kcl_csr #(
   parameter int CODE_LENGTH = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [63:0]         csr_data,
   output kcl_pkg::cfg_type    cfg,
   output logic                code_present
);

   kcl_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stored_code     <= '1;
         cfg_ff.empty_key       <= 8'd255;
         cfg_ff.lock_minutes[0] <= 8'd0;
         cfg_ff.lock_minutes[1] <= 8'd1;
         cfg_ff.lock_minutes[2] <= 8'd5;
         cfg_ff.lock_minutes[3] <= 8'd15;
         cfg_ff.lock_minutes[4] <= 8'd30;
         cfg_ff.lock_minutes[5] <= 8'd60;
      end else if (csr_write) begin
         unique case (kcl_pkg::csr_index_type'(csr_index))
            kcl_pkg::CSR_STORED_CODE: cfg_ff.stored_code     <= csr_data;
            kcl_pkg::CSR_EMPTY_KEY:   cfg_ff.empty_key       <= csr_data[7:0];
            kcl_pkg::CSR_LOCK_FIRST:  cfg_ff.lock_minutes[0] <= csr_data[7:0];
            kcl_pkg::CSR_LOCK_SECOND: cfg_ff.lock_minutes[1] <= csr_data[7:0];
            kcl_pkg::CSR_LOCK_THIRD:  cfg_ff.lock_minutes[2] <= csr_data[7:0];
            kcl_pkg::CSR_LOCK_FOURTH: cfg_ff.lock_minutes[3] <= csr_data[7:0];
            kcl_pkg::CSR_LOCK_FIFTH:  cfg_ff.lock_minutes[4] <= csr_data[7:0];
            kcl_pkg::CSR_LOCK_LAST:   cfg_ff.lock_minutes[5] <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // A code counts as stored only if none of its used digits is the empty marker.
   always_comb begin
      code_present = 1'b1;
      for (int i = 0; i < CODE_LENGTH; i++) begin
         if (cfg_ff.stored_code[8*i +: 8] == cfg_ff.empty_key) begin
            code_present = 1'b0;
         end
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/kcl_core.sv @@
module kcl_core #(
   parameter int CODE_LENGTH = 8,
   parameter int LOCK_STEPS  = 6,
   parameter int FREE_TRIES  = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [1:0]          cmd,
   input  logic [7:0]          key_code,
   input  kcl_pkg::cfg_type    cfg,
   input  logic                code_present,
   output kcl_pkg::rsp_type    result
);

   logic [7:0] digits_ff [CODE_LENGTH];
   logic [7:0] digits_in [CODE_LENGTH];
   logic [3:0] count_ff, count_in;
   logic [7:0] attempts_ff, attempts_in;
   logic       lock_ff, lock_in;
   logic [7:0] minutes_ff, minutes_in;
   logic [5:0] seconds_ff, seconds_in;

   kcl_pkg::status_type status;
   logic       take_digit;
   logic       full_entry;
   logic       match;
   logic [7:0] attempts_inc;
   logic [7:0] step_idx;

   assign full_entry = (count_ff == 4'(CODE_LENGTH - 1));
   assign attempts_inc = (attempts_ff != 8'hFF) ? attempts_ff + 8'd1 : attempts_ff;

   // The incoming key is the last digit, so the compare uses it directly.
   always_comb begin
      match = (key_code == cfg.stored_code[8*(CODE_LENGTH-1) +: 8]);
      for (int i = 0; i < CODE_LENGTH - 1; i++) begin
         if (digits_ff[i] != cfg.stored_code[8*i +: 8]) begin
            match = 1'b0;
         end
      end
   end

   always_comb begin
      step_idx = attempts_inc - 8'(FREE_TRIES);
      if (step_idx > 8'(LOCK_STEPS - 1)) begin
         step_idx = 8'(LOCK_STEPS - 1);
      end
   end

   always_comb begin
      status      = kcl_pkg::STATUS_IDLE;
      take_digit  = 1'b0;
      count_in    = count_ff;
      attempts_in = attempts_ff;
      lock_in     = lock_ff;
      minutes_in  = minutes_ff;
      seconds_in  = seconds_ff;
      unique case (kcl_pkg::cmd_type'(cmd))
         kcl_pkg::CMD_KEY: begin
            if (lock_ff) begin
               status = kcl_pkg::STATUS_REJECT;
            end else if (!full_entry) begin
               take_digit = 1'b1;
               count_in   = count_ff + 4'd1;
               status     = kcl_pkg::STATUS_DIGIT;
            end else begin
               take_digit = 1'b1;
               count_in   = 4'd0;
               if (match) begin
                  attempts_in = 8'd0;
                  status      = kcl_pkg::STATUS_MATCH;
               end else begin
                  attempts_in = attempts_inc;
                  status      = kcl_pkg::STATUS_MISMATCH;
                  if (attempts_inc >= 8'(FREE_TRIES)) begin
                     lock_in    = 1'b1;
                     minutes_in = cfg.lock_minutes[step_idx[2:0]];
                     seconds_in = (attempts_inc == 8'(FREE_TRIES)) ?
                                  kcl_pkg::FirstLockSeconds : 6'd0;
                  end
               end
            end
         end
         kcl_pkg::CMD_TIMEOUT: begin
            count_in = 4'd0;
         end
         kcl_pkg::CMD_TICK: begin
            if (lock_ff) begin
               if (seconds_ff != 6'd0) begin
                  seconds_in = seconds_ff - 6'd1;
               end else if (minutes_ff != 8'd0) begin
                  minutes_in = minutes_ff - 8'd1;
                  seconds_in = kcl_pkg::LastSecond;
               end else begin
                  lock_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   for (genvar g = 0; g < CODE_LENGTH; g++) begin : g_digit
      assign digits_in[g] = (take_digit && count_ff == 4'(g)) ? key_code : digits_ff[g];

      always_ff @(posedge clock) begin
         if (advance) begin
            digits_ff[g] <= digits_in[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= 4'd0;
         attempts_ff <= 8'd0;
         lock_ff     <= 1'b0;
         minutes_ff  <= 8'd0;
         seconds_ff  <= 6'd0;
      end else if (advance) begin
         count_ff    <= count_in;
         attempts_ff <= attempts_in;
         lock_ff     <= lock_in;
         minutes_ff  <= minutes_in;
         seconds_ff  <= seconds_in;
      end
   end

   assign result.status         = status;
   assign result.locked         = lock_in;
   assign result.minutes_left   = minutes_in;
   assign result.seconds_left   = seconds_in;
   assign result.wrong_attempts = attempts_in;
   assign result.digits_entered = count_in;
   assign result.code_present   = code_present;

endmodule

@@ rtl/kcl_checker.sv @@
`include "keypad_code_lock_lockout_assert.svh"

module kcl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic        rsp_locked,
   input logic [7:0]  rsp_minutes_left,
   input logic [5:0]  rsp_seconds_left,
   input logic [7:0]  rsp_wrong_attempts,
   input logic [3:0]  rsp_digits_entered
);

   // A response that is held back must stay put until it is taken.
   `KCL_ASSERT(a_rsp_hold, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_wrong_attempts), "response changed while stalled")

   // Outside a lockout the countdown always reads 0:00.
   `KCL_ASSERT(a_unlocked_zero, reset, rsp_valid && !rsp_locked |-> rsp_minutes_left == 8'd0 && rsp_seconds_left == 6'd0, "countdown nonzero while unlocked")

   `KCL_ASSERT(a_seconds_range, reset, rsp_valid |-> rsp_seconds_left <= kcl_pkg::LastSecond, "seconds out of range")

   // A rejected key leaves the lock engaged.
   `KCL_ASSERT(a_reject_locked, reset, rsp_valid && rsp_status == kcl_pkg::STATUS_REJECT |-> rsp_locked, "key rejected while unlocked")

   // A good code clears the attempt count and ends the entry.
   `KCL_ASSERT(a_match_clears, reset, rsp_valid && rsp_status == kcl_pkg::STATUS_MATCH |-> rsp_wrong_attempts == 8'd0 && rsp_digits_entered == 4'd0 && !rsp_locked, "match left state behind")

endmodule

bind keypad_code_lock_lockout kcl_checker u_kcl_checker (.*);
